### hdl/single_qubit_gate_state_vector_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-qubit gate state vector core
// Shared helpers that wrap concurrent assertions on the core clock and reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_QUBIT_GATE_STATE_VECTOR_CORE_DEFINES_SVH
`define SINGLE_QUBIT_GATE_STATE_VECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on aclk and disabled while aresetn is low.
`define SQG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk and disabled while aresetn is low.
`define SQG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sqg_pkg.sv
// ----------------------------------------------------------------------------
// sqg_pkg
// Types, register codes and defaults shared by the state vector gate core.
// ----------------------------------------------------------------------------
package sqg_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_BITS_DEF   = 16;
    localparam int COEF_FRAC      = 15;
    localparam int FIELD_W        = 16;
    localparam int WIDE_W         = 32;
    localparam int INDEX_W        = 10;
    localparam int CFG_IDX_W      = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_R0C0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_R0C1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_R1C0   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_R1C1   = 3'd5;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Reset values: a Hadamard-like gate with 1/sqrt(2) in Q1.15.
    localparam logic [3:0]          QUBIT_COUNT_RST = 4'd10;
    localparam logic [3:0]          TARGET_BIT_RST  = 4'd0;
    localparam logic signed [15:0]  INV_SQRT2       = 16'sd23170;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] index;
        logic signed [15:0] amp_real;
        logic signed [15:0] amp_imag;
    } sqg_in_t;

    typedef struct packed {
        logic signed [15:0] out_real;
        logic signed [15:0] out_imag;
        logic               out_of_range;
    } sqg_out_t;

    typedef struct packed {
        logic [3:0]         qubit_count;
        logic [3:0]         target_bit;
        logic signed [15:0] coef_r0c0;
        logic signed [15:0] coef_r0c1;
        logic signed [15:0] coef_r1c0;
        logic signed [15:0] coef_r1c1;
    } sqg_cfg_t;

    typedef struct packed {
        logic load_p0;
        logic load_p1;
        logic row;
        logic oor;
    } sqg_dp_ctrl_t;

endpackage

### hdl/sqg_ram.sv
// ----------------------------------------------------------------------------
// sqg_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sqg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sqg_cfg_regs.sv
// ----------------------------------------------------------------------------
// sqg_cfg_regs
// Configuration register file: qubit count, target bit and gate matrix.
// ----------------------------------------------------------------------------
module sqg_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sqg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data,
    output sqg_pkg::sqg_cfg_t               cfg
);
    import sqg_pkg::*;

    sqg_cfg_t cfg_reg;
    sqg_cfg_t cfg_next;

    // Writes are always taken; unknown indexes leave every register alone.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUBIT_COUNT: cfg_next.qubit_count = cfg_data[3:0];
                CFG_TARGET_BIT:  cfg_next.target_bit  = cfg_data[3:0];
                CFG_COEF_R0C0:   cfg_next.coef_r0c0   = $signed(cfg_data);
                CFG_COEF_R0C1:   cfg_next.coef_r0c1   = $signed(cfg_data);
                CFG_COEF_R1C0:   cfg_next.coef_r1c0   = $signed(cfg_data);
                CFG_COEF_R1C1:   cfg_next.coef_r1c1   = $signed(cfg_data);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.qubit_count <= QUBIT_COUNT_RST;
            cfg_reg.target_bit  <= TARGET_BIT_RST;
            cfg_reg.coef_r0c0   <= INV_SQRT2;
            cfg_reg.coef_r0c1   <= INV_SQRT2;
            cfg_reg.coef_r1c0   <= -INV_SQRT2;
            cfg_reg.coef_r1c1   <= INV_SQRT2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/sqg_datapath.sv
// ----------------------------------------------------------------------------
// sqg_datapath
// Shared complex-by-real multiplier, product registers, rounding and clamp.
// ----------------------------------------------------------------------------
module sqg_datapath #(
    parameter int AMP_BITS = sqg_pkg::AMP_BITS_DEF
) (
    input  logic                    aclk,
    input  sqg_pkg::sqg_dp_ctrl_t   ctrl,
    input  sqg_pkg::sqg_cfg_t       cfg,
    input  logic [2*AMP_BITS-1:0]   rdata,
    output sqg_pkg::sqg_out_t       result
);
    import sqg_pkg::*;

    localparam int PROD_W = AMP_BITS + 16;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-AMP_BITS+1){1'b0}}, {(AMP_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-AMP_BITS+1){1'b1}}, {(AMP_BITS-1){1'b0}}};

    logic signed [AMP_BITS-1:0] a_re;
    logic signed [AMP_BITS-1:0] a_im;
    logic signed [15:0]         coef_sel;
    logic signed [PROD_W-1:0]   prod_re;
    logic signed [PROD_W-1:0]   prod_im;
    logic signed [PROD_W-1:0]   p0_re_reg, p0_im_reg, p1_re_reg, p1_im_reg;
    logic signed [SUM_W-1:0]    sum_re, sum_im;
    logic signed [SUM_W-1:0]    q_re, q_im;
    logic signed [SUM_W-1:0]    c_re, c_im;

    assign a_re = $signed(rdata[AMP_BITS-1:0]);
    assign a_im = $signed(rdata[2*AMP_BITS-1:AMP_BITS]);

    // The first amplitude takes column 0 of the row, the second column 1.
    always_comb begin
        if (ctrl.row) begin
            coef_sel = ctrl.load_p1 ? cfg.coef_r1c1 : cfg.coef_r1c0;
        end else begin
            coef_sel = ctrl.load_p1 ? cfg.coef_r0c1 : cfg.coef_r0c0;
        end
    end

    assign prod_re = coef_sel * a_re;
    assign prod_im = coef_sel * a_im;

    always_ff @(posedge aclk) begin
        if (ctrl.load_p0) begin
            p0_re_reg <= prod_re;
            p0_im_reg <= prod_im;
        end
        if (ctrl.load_p1) begin
            p1_re_reg <= prod_re;
            p1_im_reg <= prod_im;
        end
    end

    assign sum_re = SUM_W'(p0_re_reg) + SUM_W'(p1_re_reg);
    assign sum_im = SUM_W'(p0_im_reg) + SUM_W'(p1_im_reg);

    // Round half up, then an arithmetic shift floors the scaled value.
    assign q_re = (sum_re + ROUND_HALF) >>> COEF_FRAC;
    assign q_im = (sum_im + ROUND_HALF) >>> COEF_FRAC;

    always_comb begin
        priority if (q_re > SAT_HI) c_re = SAT_HI;
        else if (q_re < SAT_LO)     c_re = SAT_LO;
        else                        c_re = q_re;
        priority if (q_im > SAT_HI) c_im = SAT_HI;
        else if (q_im < SAT_LO)     c_im = SAT_LO;
        else                        c_im = q_im;
    end

    always_comb begin
        if (ctrl.oor) begin
            result.out_real     = '0;
            result.out_imag     = '0;
            result.out_of_range = 1'b1;
        end else begin
            result.out_real     = 16'(c_re);
            result.out_imag     = 16'(c_im);
            result.out_of_range = 1'b0;
        end
    end

endmodule

### hdl/single_qubit_gate_state_vector_core.sv
// Write item: one transfer per cycle while idle, no result; the store is written in the accept
// cycle. Read item: the sequencer steps through RD1, MUL and SUM and puts the result into the
// output register once it is free; only then is new input taken. Out-of-range read: straight
// to SUM. A read's steps are two single-port RAM reads, the second product and the sum.
// Reset (synchronous, aresetn low) restores state, valid and config; the RAM is not cleared.
// ----------------------------------------------------------------------------
// single_qubit_gate_state_vector_core
// Stores a state vector of complex amplitudes and returns one row of a real
// 2x2 gate applied on the configured target qubit for each read item.
// ----------------------------------------------------------------------------
`include "single_qubit_gate_state_vector_core_defines.svh"

module single_qubit_gate_state_vector_core #(
    parameter int MAX_QUBITS = sqg_pkg::MAX_QUBITS_DEF,
    parameter int AMP_BITS   = sqg_pkg::AMP_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sqg_pkg::sqg_in_t                s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sqg_pkg::sqg_out_t               m_payload,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sqg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data
);
    import sqg_pkg::*;

    localparam int ADDR_W = MAX_QUBITS;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int WORD_W = 2 * AMP_BITS;
    localparam int CNT_W  = $clog2(MAX_QUBITS + 1);

    // Sequencer states. A read walks RD1 (second address out, first word back),
    // MUL (second word back) and SUM (result into the output register).
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD1  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    sqg_cfg_t     cfg;
    sqg_dp_ctrl_t ctrl;
    sqg_out_t     dp_result;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] i1_reg, i1_next;
    logic              row_reg, row_next;
    logic              oor_reg, oor_next;
    logic              m_valid_reg, m_valid_next;
    sqg_out_t          m_payload_reg, m_payload_next;

    logic [CNT_W-1:0]  count;
    logic              idx_ok;
    logic              tgt_ok;
    logic [ADDR_W-1:0] idx_a;
    logic [ADDR_W-1:0] tgt_mask;
    logic [WIDE_W-1:0] re_wide, im_wide;
    logic              in_xfer;
    logic              out_free;

    logic              mem_en;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] mem_rdata;

    sqg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A qubit count above what the store can hold behaves as the maximum.
    always_comb begin
        if (int'(cfg.qubit_count) > MAX_QUBITS) begin
            count = CNT_W'(MAX_QUBITS);
        end else begin
            count = CNT_W'(cfg.qubit_count);
        end
    end

    assign idx_ok   = (s_payload.index >> count) == '0;
    assign tgt_ok   = int'(cfg.target_bit) < int'(count);
    assign idx_a    = ADDR_W'(s_payload.index);
    assign tgt_mask = ADDR_W'(1) << cfg.target_bit;

    // Stored parts are the low AMP_BITS bits of the sign-extended input fields;
    // the datapath reads them back as signed values.
    assign re_wide   = {{(WIDE_W-FIELD_W){s_payload.amp_real[FIELD_W-1]}}, s_payload.amp_real};
    assign im_wide   = {{(WIDE_W-FIELD_W){s_payload.amp_imag[FIELD_W-1]}}, s_payload.amp_imag};
    assign mem_wdata = {im_wide[AMP_BITS-1:0], re_wide[AMP_BITS-1:0]};

    // Only an idle sequencer takes an input transfer. The output register
    // decouples the two sides: a waiting result blocks input only once a read is held in SUM.
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        i1_next        = i1_reg;
        row_next       = row_reg;
        oor_next       = oor_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = idx_a;
        ctrl.load_p0   = 1'b0;
        ctrl.load_p1   = 1'b0;
        ctrl.row       = row_reg;
        ctrl.oor       = oor_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_payload.operation == OP_WRITE) begin
                        // Out-of-range writes are dropped.
                        mem_en = idx_ok;
                        mem_we = idx_ok;
                    end else if (idx_ok && tgt_ok) begin
                        // First read goes out with the target bit cleared.
                        mem_en     = 1'b1;
                        mem_addr   = idx_a & ~tgt_mask;
                        i1_next    = idx_a | tgt_mask;
                        row_next   = |(idx_a & tgt_mask);
                        oor_next   = 1'b0;
                        state_next = ST_RD1;
                    end else begin
                        oor_next   = 1'b1;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_RD1: begin
                mem_en       = 1'b1;
                mem_addr     = i1_reg;
                ctrl.load_p0 = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                ctrl.load_p1 = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = dp_result;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sqg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_amp_ram (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sqg_datapath #(
        .AMP_BITS (AMP_BITS)
    ) u_dp (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .cfg    (cfg),
        .rdata  (mem_rdata),
        .result (dp_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i1_reg        <= i1_next;
        row_reg       <= row_next;
        oor_reg       <= oor_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // The store is written only for an accepted write item.
    `SQG_ASSERT_IMP(a_we_from_write, mem_we,
        s_valid && s_ready && s_payload.operation == OP_WRITE,
        "amplitude store written without a write transfer")

    // The first product is always followed by the second one.
    `SQG_ASSERT_NXT(a_p0_then_p1, ctrl.load_p0, ctrl.load_p1,
        "second product did not follow the first")

    // A new result appears only out of the final sequencer step.
    `SQG_ASSERT_IMP(a_result_from_sum, $rose(m_valid_reg), $past(state_reg) == ST_SUM,
        "result raised outside the final step")

    // An out-of-range result carries zero values.
    `SQG_ASSERT_IMP(a_oor_zero, m_valid_reg && m_payload_reg.out_of_range,
        m_payload_reg.out_real == '0 && m_payload_reg.out_imag == '0,
        "out-of-range result with nonzero values")

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for single_qubit_gate_state_vector_core
// Drives amplitude writes and gated reads through the valid/ready input
// channel, reprograms the gate between phases, and checks every result
// against a cycle-free behavioral model of the gate kept inside this module.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sqg_pkg::*;

    // Run sizing. The cycle limit allows every item its longest sender gap,
    // its slowest read and the longest result stall, several times over.
    localparam int          RANDOM_ITEMS  = 1300;
    localparam int          PHASE_ITEMS   = 130;
    localparam int          SETTLE_CYCLES = 8;
    localparam longint      CYCLE_LIMIT   = 800000;
    localparam int          MAX_PRINTS    = 30;
    localparam int          STORE_DEPTH   = 1 << MAX_QUBITS_DEF;

    // Register indexes past the last gate coefficient; the core has no
    // register behind them and must leave its settings alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Every block input starts at a known value, reset included.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sqg_in_t              s_payload = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sqg_out_t             m_payload;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    single_qubit_gate_state_vector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Items waiting for the input driver, and gated amplitudes still owed by
    // the core, oldest first.
    sqg_in_t  stim_q[$];
    sqg_out_t gated_amps_due[$];

    // Handshake flags sampled at the rising edge and consumed by the drivers
    // at the following falling edge.
    bit s_taken   = 1'b0;
    bit cfg_taken = 1'b0;

    // When clear, neither side inserts gaps: this gives back-to-back stretches.
    bit idle_on = 1'b0;

    // Shadow of the gate settings and of the amplitude memory, updated on each
    // accepted transfer exactly as the core should update its own.
    logic [3:0]         qubits_reg;
    logic [3:0]         target_reg;
    logic signed [15:0] coef_q [2][2];
    logic signed [15:0] amp_re [STORE_DEPTH];
    logic signed [15:0] amp_im [STORE_DEPTH];

    // Stimulus-side view: which memory entries hold a written amplitude, and
    // the settings that the queued items will meet. Reads are only planned
    // when both entries of their pair are loaded.
    bit          loaded [STORE_DEPTH];
    int unsigned plan_eff;
    int unsigned plan_target;
    int unsigned planned;

    // Bookkeeping.
    longint      cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned n_writes    = 0;
    int unsigned n_reads     = 0;
    int unsigned n_oor_reads = 0;
    int unsigned n_results   = 0;
    int unsigned n_settings  = 1;

    // ------------------------------------------------------------------------
    // Clock: 8 ns period.
    // ------------------------------------------------------------------------
    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Gate arithmetic. The sum is in Q3.30; adding half an LSB and shifting
    // arithmetically gives round to nearest with ties toward plus infinity.
    // ------------------------------------------------------------------------
    function automatic logic signed [15:0] round_q15(input longint sum);
        longint q;
        q = (sum + 64'sd16384) >>> COEF_FRAC;
        if (q > 64'sd32767) return 16'sh7FFF;
        if (q < -64'sd32768) return 16'sh8000;
        return q[15:0];
    endfunction

    // Applies one accepted input transfer to the shadow memory. A read pushes
    // the gated amplitude it must produce; a write produces nothing.
    task automatic track_gate_item(input sqg_in_t it);
        int unsigned eff;
        bit          in_range;
        logic [9:0]  bitm;
        logic [9:0]  i0;
        logic [9:0]  i1;
        logic        row;
        longint      re_sum;
        longint      im_sum;
        sqg_out_t    want;
        eff = (qubits_reg > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : qubits_reg;
        in_range = ((32'(it.index) >> eff) == 0);
        if (it.operation == OP_WRITE) begin
            // Writes outside the active qubit range are dropped.
            if (in_range) begin
                amp_re[it.index] = it.amp_real;
                amp_im[it.index] = it.amp_imag;
                n_writes++;
            end
            return;
        end
        n_reads++;
        if (!in_range || target_reg >= eff) begin
            want = '{out_real: '0, out_imag: '0, out_of_range: 1'b1};
            n_oor_reads++;
        end else begin
            bitm   = 10'd1 << target_reg;
            i0     = it.index & ~bitm;
            i1     = it.index | bitm;
            row    = |(it.index & bitm);
            re_sum = longint'(coef_q[row][0]) * longint'(amp_re[i0])
                   + longint'(coef_q[row][1]) * longint'(amp_re[i1]);
            im_sum = longint'(coef_q[row][0]) * longint'(amp_im[i0])
                   + longint'(coef_q[row][1]) * longint'(amp_im[i1]);
            want = '{out_real: round_q15(re_sum), out_imag: round_q15(im_sum),
                     out_of_range: 1'b0};
        end
        gated_amps_due.push_back(want);
    endtask

    task automatic track_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            CFG_QUBIT_COUNT: qubits_reg   = data[3:0];
            CFG_TARGET_BIT:  target_reg   = data[3:0];
            CFG_COEF_R0C0:   coef_q[0][0] = data;
            CFG_COEF_R0C1:   coef_q[0][1] = data;
            CFG_COEF_R1C0:   coef_q[1][0] = data;
            CFG_COEF_R1C1:   coef_q[1][1] = data;
            default: ;
        endcase
    endtask

    // One line per mismatch, capped so a broken core cannot flood the log.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the core's
    // own updates for that edge take effect.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        sqg_out_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", gated_amps_due.size());
            $display("Verification failed");
            $finish;
        end else if (!aresetn) begin
            s_taken      = 1'b0;
            cfg_taken    = 1'b0;
            qubits_reg   = QUBIT_COUNT_RST;
            target_reg   = TARGET_BIT_RST;
            coef_q[0][0] = INV_SQRT2;
            coef_q[0][1] = INV_SQRT2;
            coef_q[1][0] = -INV_SQRT2;
            coef_q[1][1] = INV_SQRT2;
        end else begin
            // Results are checked before this edge's input transfer is
            // modeled; the core cannot answer a read in the cycle it takes it.
            if (m_valid && m_ready) begin
                n_results++;
                if (gated_amps_due.size() == 0) begin
                    report_mismatch("result with none expected, out_real", m_payload.out_real, 0);
                end else begin
                    want = gated_amps_due.pop_front();
                    if (m_payload.out_real !== want.out_real)
                        report_mismatch("out_real", m_payload.out_real, want.out_real);
                    if (m_payload.out_imag !== want.out_imag)
                        report_mismatch("out_imag", m_payload.out_imag, want.out_imag);
                    if (m_payload.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", m_payload.out_of_range,
                                        want.out_of_range);
                end
            end
            s_taken = s_valid && s_ready;
            if (s_taken) track_gate_item(s_payload);
            cfg_taken = cfg_valid && cfg_ready;
            if (cfg_taken) track_register(cfg_index, cfg_data);
        end
    end

    // Gap lengths: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 65) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. The payload only moves once the current item has been
    // transferred, so valid never drops or changes under a waiting item.
    // ------------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (stim_q.size() > 0) begin
                s_payload <= stim_q.pop_front();
                s_valid   <= 1'b1;
                send_gap   = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, drawn from the same gap profile.
    int unsigned stall_left = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic logic [15:0] pick_amp();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return INV_SQRT2;
            3:       return -INV_SQRT2;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_write(input int unsigned idx, input logic [15:0] re,
                               input logic [15:0] im);
        sqg_in_t it;
        it.operation = OP_WRITE;
        it.index     = idx[9:0];
        it.amp_real  = re;
        it.amp_imag  = im;
        stim_q.push_back(it);
        planned++;
        if ((idx >> plan_eff) == 0) begin
            loaded[idx] = 1'b1;
        end
    endtask

    // A read that will be served first gets any missing pair entry written,
    // so no read ever touches an entry that was never loaded. The amplitude
    // fields of a read carry random bits that the core must ignore.
    task automatic queue_read(input int unsigned idx);
        sqg_in_t     it;
        int unsigned bitm;
        if ((idx >> plan_eff) == 0 && plan_target < plan_eff) begin
            bitm = 1 << plan_target;
            if (!loaded[idx & ~bitm]) queue_write(idx & ~bitm, pick_amp(), pick_amp());
            if (!loaded[idx | bitm])  queue_write(idx | bitm, pick_amp(), pick_amp());
        end
        it.operation = OP_READ;
        it.index     = idx[9:0];
        it.amp_real  = 16'($urandom);
        it.amp_imag  = 16'($urandom);
        stim_q.push_back(it);
        planned++;
    endtask

    // Returns once the sender has run dry and every owed result has arrived,
    // then lets a few more cycles pass for writes still settling in the core.
    task automatic wait_drained();
        while (stim_q.size() != 0 || s_valid || gated_amps_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Reprograms the whole gate with the core idle. The count and target
    // writes carry random upper bits that the core must drop.
    task automatic set_gate(input int unsigned count, input int unsigned target,
                            input logic [15:0] c00, input logic [15:0] c01,
                            input logic [15:0] c10, input logic [15:0] c11);
        wait_drained();
        write_register(CFG_QUBIT_COUNT, {12'($urandom), 4'(count)});
        write_register(CFG_TARGET_BIT,  {12'($urandom), 4'(target)});
        write_register(CFG_COEF_R0C0, c00);
        write_register(CFG_COEF_R0C1, c01);
        write_register(CFG_COEF_R1C0, c10);
        write_register(CFG_COEF_R1C1, c11);
        plan_eff    = (count > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : count;
        plan_target = target;
        idle_on     = ($urandom_range(0, 3) != 0);
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed corners, then random phases.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned rphase;
        int unsigned phase_end;
        int unsigned roll;
        int unsigned cnt;
        int unsigned eff;
        int unsigned tgt;
        bit          hold;
        bit          held;

        plan_eff    = MAX_QUBITS_DEF;
        plan_target = 0;
        planned     = 0;
        idle_on     = 1'b1;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset gate (Hadamard-like, target 0, all ten qubits). Full-scale
        // amplitudes of both signs at the two ends of the index range; the
        // second read carries amplitude bits that must be ignored.
        queue_write(0, 16'h7FFF, 16'h8000);
        queue_write(1, 16'h8000, 16'h7FFF);
        queue_read(0);
        queue_read(1);
        queue_write(1023, 16'h8000, 16'h8000);
        queue_write(1022, 16'h8000, 16'h8000);
        queue_read(1023);
        queue_read(1022);
        queue_write(3, 16'h0001, 16'hFFFF);

        // Three qubits, target bit 2, every coefficient at the negative
        // extreme: products of two negative extremes saturate high. Index 8
        // lies outside the range, so its write is dropped and its read flags.
        set_gate(3, 2, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_write(4, 16'h8000, 16'h7FFF);
        queue_write(5, 16'h8000, 16'h7FFF);
        queue_write(7, 16'h7FFF, 16'h8000);
        queue_write(8, 16'h1234, 16'h4321);
        queue_read(0);
        queue_read(5);
        queue_read(7);
        queue_read(8);
        queue_read(1023);

        // Indexes with no register behind them must change nothing.
        wait_drained();
        write_register(CFG_SPARE_LO, 16'($urandom));
        write_register(CFG_SPARE_HI, 16'($urandom));

        // Zero qubits: only index 0 can be written and no read is served,
        // since the target can never lie below the count.
        set_gate(0, 0, INV_SQRT2, INV_SQRT2, -INV_SQRT2, INV_SQRT2);
        queue_read(0);
        queue_write(0, 16'h4000, 16'hC000);
        queue_write(1, 16'h2000, 16'h2000);
        queue_read(1);

        // A count above the maximum acts as ten qubits; top target bit with
        // every coefficient at the positive extreme.
        set_gate(15, 9, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_write(511, 16'h7FFF, 16'h7FFF);
        queue_read(1023);
        queue_read(511);

        // Target bit beyond the count: every read is flagged.
        set_gate(10, 15, INV_SQRT2, INV_SQRT2, -INV_SQRT2, INV_SQRT2);
        queue_read(5);

        // Random phases. Most items are reads whose pair is loaded first, so
        // the datapath sees real work; the rest are plain writes, dropped
        // writes and flagged reads. The first phase also stops the sender
        // halfway until everything owed has come back.
        planned = 0;
        rphase  = 0;
        while (planned < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 9);
            if (rphase == 0 || roll < 3) cnt = 10;
            else if (roll < 8)           cnt = $urandom_range(1, 9);
            else if (roll == 8)          cnt = 0;
            else                         cnt = $urandom_range(11, 15);
            eff = (cnt > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : cnt;
            if (eff > 0 && $urandom_range(0, 7) != 0) tgt = $urandom_range(0, eff - 1);
            else                                      tgt = $urandom_range(0, 15);
            set_gate(cnt, tgt, pick_coef(), pick_coef(), pick_coef(), pick_coef());

            phase_end = planned + PHASE_ITEMS;
            hold      = (rphase == 0) || ($urandom_range(0, 2) == 0);
            held      = 1'b0;
            while (planned < phase_end) begin
                if (hold && !held && planned + PHASE_ITEMS / 2 >= phase_end) begin
                    wait_drained();
                    held = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    queue_read($urandom_range(0, (1 << plan_eff) - 1));
                end else if (roll < 80 || (roll >= 90 && plan_eff == MAX_QUBITS_DEF)) begin
                    queue_write($urandom_range(0, (1 << plan_eff) - 1), pick_amp(), pick_amp());
                end else if (roll < 90) begin
                    if (plan_eff < MAX_QUBITS_DEF)
                        queue_read($urandom_range(1 << plan_eff, STORE_DEPTH - 1));
                    else
                        queue_read($urandom_range(0, STORE_DEPTH - 1));
                end else begin
                    queue_write($urandom_range(1 << plan_eff, STORE_DEPTH - 1),
                                pick_amp(), pick_amp());
                end
            end
            rphase++;
        end

        wait_drained();
        $display("Covered %0d stored writes and %0d reads (%0d flagged out of range)",
                 n_writes, n_reads, n_oor_reads);
        $display("across %0d gate settings; %0d results checked", n_settings, n_results);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
